// ===== src/hex_ascii_frame_encoder_crc32_unit_macros.svh =====
// Assertion helpers for the RTL; only hafe_seq.sv includes them.
`ifndef HEX_ASCII_FRAME_ENCODER_CRC32_UNIT_MACROS_SVH
`define HEX_ASCII_FRAME_ENCODER_CRC32_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define HAFE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hafe: same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define HAFE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hafe: next-cycle check failed");

`endif

// ===== src/hafe_pkg.sv =====
`default_nettype none

package hafe_pkg;

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [6:0]  CH_OPEN      = 7'h3C;
    localparam logic [6:0]  CH_NEWLINE   = 7'h0A;
    localparam logic [6:0]  CH_ZERO      = 7'h30;
    localparam logic [6:0]  CH_UPPER_A   = 7'h41;
    localparam logic [6:0]  CH_HEX_ALPHA = CH_UPPER_A - 7'd10;
    localparam int          CRC_DIGITS   = 8;
    localparam int          DIG_W        = $clog2(CRC_DIGITS);

    typedef logic [31:0] t_crc_tab [256];

    typedef enum logic [2:0] {
        S_IDLE,
        S_OPEN,
        S_HI,
        S_LO,
        S_CRC,
        S_NL
    } t_seq_state;

    // Running frame state handed from the CRC unit to the sequencer.
    typedef struct packed {
        logic        frame_open;
        logic [31:0] crc;
    } t_crc_state;

    // One character word on its way to the output register.
    typedef struct packed {
        logic       vld;
        logic [6:0] ch;
        logic       frame_end;
    } t_char_word;

    // Reflected CRC-32 byte table, built at elaboration.
    function automatic t_crc_tab build_crc_tab();
        t_crc_tab    tab;
        logic [31:0] c;
        for (int i = 0; i < 256; i++) begin
            c = 32'(i);
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            tab[i] = c;
        end
        return tab;
    endfunction

    localparam t_crc_tab CRC_TAB = build_crc_tab();

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] ext;
        ext = {3'b000, nib};
        if (nib < 4'd10) begin
            return CH_ZERO + ext;
        end
        return CH_HEX_ALPHA + ext;
    endfunction

endpackage

`default_nettype wire

// ===== src/hafe_crc.sv =====
`default_nettype none

module hafe_crc
    import hafe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output t_crc_state      o_state
);

    logic        r_open;
    logic [31:0] r_crc;
    logic        n_open;
    logic [31:0] n_crc;
    logic [31:0] base;

    // A closed frame restarts from zero; the final CRC stays readable until then.
    assign base = r_open ? r_crc : 32'h0;

    always_comb begin
        n_open = r_open;
        n_crc  = r_crc;
        if (i_load) begin
            n_open = ~i_last;
            n_crc  = (base >> 8) ^ CRC_TAB[base[7:0] ^ i_byte];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_crc  <= 32'h0;
        end else begin
            r_open <= n_open;
            r_crc  <= n_crc;
        end
    end

    assign o_state.frame_open = r_open;
    assign o_state.crc        = r_crc;

endmodule

`default_nettype wire

// ===== src/hafe_seq.sv =====
`default_nettype none

module hafe_seq
    import hafe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    input  wire t_crc_state i_crc,
    input  wire logic       i_out_rdy,
    output logic            o_free,
    output t_char_word      o_word
);

    `include "hex_ascii_frame_encoder_crc32_unit_macros.svh"

    t_seq_state       r_state;
    t_seq_state       n_state;
    logic [7:0]       r_byte;
    logic             r_last;
    logic [DIG_W-1:0] r_dig;
    logic [DIG_W-1:0] n_dig;
    logic             adv;
    logic             done;
    logic [4:0]       crc_shift;
    logic [3:0]       crc_nib;

    assign adv  = i_out_rdy && (r_state != S_IDLE);
    assign done = adv && (((r_state == S_LO) && !r_last) || (r_state == S_NL));
    assign o_free = (r_state == S_IDLE) || done;

    // Next state
    always_comb begin
        n_state = r_state;
        if (i_load) begin
            n_state = i_crc.frame_open ? S_HI : S_OPEN;
        end else if (adv) begin
            unique case (r_state)
                S_OPEN:  n_state = S_HI;
                S_HI:    n_state = S_LO;
                S_LO:    n_state = r_last ? S_CRC : S_IDLE;
                S_CRC:   n_state = (r_dig == DIG_W'(CRC_DIGITS - 1)) ? S_NL : S_CRC;
                S_NL:    n_state = S_IDLE;
                default: n_state = S_IDLE;
            endcase
        end
    end

    always_comb begin
        n_dig = '0;
        if (r_state == S_CRC) begin
            n_dig = adv ? r_dig + 1'b1 : r_dig;
        end
    end

    // CRC goes out low byte first, high nibble of each byte first.
    assign crc_shift = {r_dig[DIG_W-1:1], ~r_dig[0], 2'b00};
    assign crc_nib   = 4'(i_crc.crc >> crc_shift);

    // Outputs
    always_comb begin
        o_word.vld       = (r_state != S_IDLE);
        o_word.frame_end = 1'b0;
        unique case (r_state)
            S_OPEN: o_word.ch = CH_OPEN;
            S_HI:   o_word.ch = hex_char(r_byte[7:4]);
            S_LO:   o_word.ch = hex_char(r_byte[3:0]);
            S_CRC:  o_word.ch = hex_char(crc_nib);
            S_NL: begin
                o_word.ch        = CH_NEWLINE;
                o_word.frame_end = 1'b1;
            end
            default: o_word.ch = CH_NEWLINE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dig   <= '0;
        end else begin
            r_state <= n_state;
            r_dig   <= n_dig;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte <= i_byte;
            r_last <= i_last;
        end
    end

    `HAFE_ASSERT_SAME(a_load_only_when_free, i_load, o_free)
    `HAFE_ASSERT_SAME(a_dig_clear_outside_crc, r_state != S_CRC, r_dig == '0)
    `HAFE_ASSERT_NEXT(a_done_goes_idle, done && !i_load, r_state == S_IDLE)
    `HAFE_ASSERT_NEXT(a_load_starts_item, i_load, r_state == S_OPEN || r_state == S_HI)

endmodule

`default_nettype wire

// ===== src/hafe_oreg.sv =====
`default_nettype none

module hafe_oreg
    import hafe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_char_word i_word,
    input  wire logic       i_stall,
    output logic            o_rdy,
    output logic            o_valid,
    output logic [6:0]      o_ch,
    output logic            o_frame_end
);

    logic       r_valid;
    logic [6:0] r_ch;
    logic       r_end;

    // Take a new word whenever the held one is gone or leaves this cycle.
    assign o_rdy = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_rdy) begin
            r_valid <= i_word.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_word.vld) begin
            r_ch  <= i_word.ch;
            r_end <= i_word.frame_end;
        end
    end

    assign o_valid     = r_valid;
    assign o_ch        = r_ch;
    assign o_frame_end = r_end;

endmodule

`default_nettype wire

// ===== src/hex_ascii_frame_encoder_crc32_unit.sv =====
`default_nettype none

// Frames payload bytes as a line of ASCII hex text with a CRC-32 trailer.
// Each input word is one payload byte plus a last-byte flag; each output word
// is one 7-bit character plus a frame-end flag. A frame reads '<', then two
// uppercase hex digits per byte (high nibble first), then the reflected
// CRC-32 of the payload (poly 0xEDB88320, seed 0, no final inversion) as
// eight digits, low byte first, and finally a newline with frame_end set.
// One character leaves per cycle while the output is not stalled; the output
// register sets that pace. A middle byte yields two characters, the byte
// that opens a frame three, and the closing byte nine more for the trailer.
// The next byte is taken in the same cycle the last character of the current
// one enters the output register, and a word waiting at the output does not
// keep the input stalled once the sequencer is free. The CRC is a one-step
// table lookup per byte, so throughput is set by characters and stalls.

module hex_ascii_frame_encoder_crc32_unit
    import hafe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [6:0]      o_ascii_char,
    output logic            o_frame_end
);

    logic       seq_free;
    logic       in_accept;
    logic       out_rdy;
    t_crc_state crc_state;
    t_char_word char_word;

    // Hold the input off until the sequencer finishes the byte in hand.
    assign o_in_stall = ~seq_free;
    assign in_accept  = i_in_valid && seq_free;

    // Running CRC and frame-open flag, advanced once per accepted byte.
    hafe_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_accept),
        .i_byte  (i_data_byte),
        .i_last  (i_last_byte),
        .o_state (crc_state)
    );

    // Walk the characters of one byte: open mark, digits, trailer, newline.
    hafe_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (in_accept),
        .i_byte    (i_data_byte),
        .i_last    (i_last_byte),
        .i_crc     (crc_state),
        .i_out_rdy (out_rdy),
        .o_free    (seq_free),
        .o_word    (char_word)
    );

    // Output register: holds a stalled word, refills as it drains.
    hafe_oreg u_oreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (char_word),
        .i_stall     (i_out_stall),
        .o_rdy       (out_rdy),
        .o_valid     (o_out_valid),
        .o_ch        (o_ascii_char),
        .o_frame_end (o_frame_end)
    );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import hafe_pkg::*;

    // Drop the run when this many cycles pass with no word moving on either side.
    localparam int IDLE_LIMIT = 2000;
    // Drain margin after the last expected word: one full frame trailer and then some.
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_WORDS = 400;
    localparam int DIR_ROWS = 18;

    // One character word as it leaves the block.
    typedef struct packed {
        logic [6:0] ch;
        logic       fe;
    } line_char_t;

    // One directed stimulus row. A row with n_text of zero is checked against the
    // predictor; otherwise the characters in text (left to right) are the answer.
    typedef struct {
        logic [7:0]  data;
        logic        last;
        int          n_text;
        logic [95:0] text;
    } stim_row_t;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_data_byte;
    logic       i_last_byte;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [6:0] o_ascii_char;
    logic       o_frame_end;

    hex_ascii_frame_encoder_crc32_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_ascii_char (o_ascii_char),
        .o_frame_end  (o_frame_end)
    );

    // Characters still owed by the block, oldest first.
    line_char_t  pending_chars[$];
    line_char_t  mon_want;

    // Predictor copy of the framing state.
    logic        frame_open_q;
    logic [31:0] frame_crc_q;

    int          err_cnt;
    int          idle_cycles;
    int          out_words;
    // Set to run a stretch with no gaps and no stalls on either side.
    logic        no_idle;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [6:0] nibble_char(input logic [3:0] nib);
        if (nib <= 4'd9) begin
            return CH_ZERO + 7'(nib);
        end
        return CH_UPPER_A + 7'(nib - 4'd10);
    endfunction

    // Bitwise reflected CRC-32 step over one byte.
    function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic push_hex(input logic [7:0] b);
        pending_chars.push_back('{nibble_char(b[7:4]), 1'b0});
        pending_chars.push_back('{nibble_char(b[3:0]), 1'b0});
    endtask

    // Advance the framing state by one payload byte; queue the characters it
    // produces when push_en is set.
    task automatic predict_line_chars(input logic [7:0] b, input logic last, input logic push_en);
        if (!frame_open_q) begin
            if (push_en) pending_chars.push_back('{CH_OPEN, 1'b0});
            frame_open_q = 1'b1;
            frame_crc_q  = 32'h0;
        end
        frame_crc_q = crc_step(frame_crc_q, b);
        if (push_en) push_hex(b);
        if (last) begin
            if (push_en) begin
                // Trailer goes out low byte first.
                for (int k = 0; k < 4; k++) begin
                    push_hex(frame_crc_q[8*k +: 8]);
                end
                pending_chars.push_back('{CH_NEWLINE, 1'b1});
            end
            frame_open_q = 1'b0;
            frame_crc_q  = 32'h0;
        end
    endtask

    // Present one payload word, hold it until taken, then book its characters.
    task automatic send_byte(input logic [7:0] b, input logic last, input int n_text,
                             input logic [95:0] text);
        int         gap;
        logic [6:0] c;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        // Inputs read right after the edge still show pre-edge values.
        do @(posedge i_clk); while (o_in_stall);
        predict_line_chars(b, last, n_text == 0);
        for (int k = 0; k < n_text; k++) begin
            c = text[8*(n_text-1-k) +: 7];
            pending_chars.push_back('{c, c == CH_NEWLINE});
        end
    endtask

    // Receiver side: stall at random, with calm stretches in between.
    initial begin
        int n;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Check every word the block hands over, and watch for a hang.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                out_words++;
                if (pending_chars.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("word %0d not expected: char %h end %b",
                                 out_words, o_ascii_char, o_frame_end);
                    end
                end else begin
                    mon_want = pending_chars.pop_front();
                    if (o_ascii_char !== mon_want.ch || o_frame_end !== mon_want.fe) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $display("word %0d: expected char %h end %b, got char %h end %b",
                                     out_words, mon_want.ch, mon_want.fe,
                                     o_ascii_char, o_frame_end);
                        end
                    end
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("*** FAILED ***");
                    $finish;
                end
            end
        end
    end

    initial begin
        stim_row_t dir_tab[DIR_ROWS];
        int        sent;
        int        len;

        err_cnt      = 0;
        idle_cycles  = 0;
        out_words    = 0;
        no_idle      = 1'b0;
        frame_open_q = 1'b0;
        frame_crc_q  = 32'h0;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_data_byte <= 8'h00;
        i_last_byte <= 1'b0;

        // Single zero byte: CRC stays zero, so the whole line is plain zeros.
        dir_tab[0]  = '{8'h00, 1'b1, 12, "<0000000000\n"};
        // Open a frame with the top value, then a zero in the middle.
        dir_tab[1]  = '{8'hFF, 1'b0, 3, "<FF"};
        dir_tab[2]  = '{8'h00, 1'b0, 2, "00"};
        dir_tab[3]  = '{8'hA5, 1'b0, 0, 96'h0};
        dir_tab[4]  = '{8'h5A, 1'b1, 0, 96'h0};
        // Single-byte frame with every data bit set.
        dir_tab[5]  = '{8'hFF, 1'b1, 0, 96'h0};
        // Walk all sixteen hex digits: even ones in the high nibble, odd ones in the low.
        dir_tab[6]  = '{8'h01, 1'b0, 3, "<01"};
        dir_tab[7]  = '{8'h23, 1'b0, 2, "23"};
        dir_tab[8]  = '{8'h45, 1'b0, 2, "45"};
        dir_tab[9]  = '{8'h67, 1'b0, 2, "67"};
        dir_tab[10] = '{8'h89, 1'b0, 2, "89"};
        dir_tab[11] = '{8'hAB, 1'b0, 2, "AB"};
        dir_tab[12] = '{8'hCD, 1'b0, 2, "CD"};
        dir_tab[13] = '{8'hEF, 1'b1, 0, 96'h0};
        // Fresh frame right after a close: the CRC must restart from zero.
        dir_tab[14] = '{8'h80, 1'b0, 0, 96'h0};
        dir_tab[15] = '{8'h7F, 1'b0, 0, 96'h0};
        dir_tab[16] = '{8'h10, 1'b0, 0, 96'h0};
        dir_tab[17] = '{8'h0F, 1'b1, 0, 96'h0};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].n_text, dir_tab[i].text);
        end

        // Random frames: mostly short, a few long, every one closed.
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            if ($urandom_range(0, 7) == 0) begin
                no_idle = ~no_idle;
            end
            len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 40);
            for (int k = 0; k < len; k++) begin
                send_byte(8'($urandom_range(0, 255)), k == len - 1, 0, 96'h0);
            end
            sent += len;
        end
        no_idle = 1'b0;
        i_in_valid <= 1'b0;

        // Drain: wait for every owed character, then hold a while for strays.
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
